// ----- rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

    // width of the capacity register
    localparam int CAP_W     = 7;
    // capacity after reset
    localparam int CAP_RESET = 64;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_POP_FRONT  = 2'd1,
        REQ_PUSH_BACK  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] push_value;
    } t_req_word;

    typedef struct packed {
        logic signed [31:0] pop_value;
        t_status            status;
    } t_rsp_word;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input word, start the slot read
        logic exec;      // apply the request to indices and store
        logic load_out;  // move the result into the output register
    } t_cdq_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_cdq_sts;

endpackage

// ----- rtl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue in a circular slot store with programmable capacity
// ----------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+--------------------------------
//  request  | i_in_valid / o_in_ready   | i_in_word  (req_type, push_value)
//  result   | o_out_valid / i_out_ready | o_out_word (pop_value, status)
//  config   | i_cfg_we                  | i_cfg_wdata (capacity)
//
//  each request passes through accept and slot read, execute with slot
//  write and index update, and load of the output register; the registered
//  read of the slot store is why accept and execute are separate steps
//  a stalled result holds the sequencer in its load step; a new request is
//  taken as soon as the result has moved into the output register
//  synchronous active-low reset empties the deque and sets capacity 64
//  (or DEPTH if smaller); store contents are not cleared
//  a capacity write empties the deque and keeps the store contents
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request side
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req_word        i_in_word,
    // result side
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp_word        o_out_word,
    // capacity register
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    // command and status between sequencer and datapath
    t_cdq_cmd w_cmd;
    t_cdq_sts w_sts;

    // sequencer: idle, execute, load output
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // indices, slot store and output register
    cdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- rtl/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// request sequencer: capture, execute, hand over to the output register
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cdq_sts i_sts,
    output t_cdq_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // an accepted word is always executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

endmodule

// ----- rtl/cdq_dp.sv -----
// ----------------------------------------------------------------------------
// cdq_dp
// deque datapath: indices, slot store, result and output registers
// ----------------------------------------------------------------------------
module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req_word        i_in_word,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  t_cdq_cmd         i_cmd,
    output t_cdq_sts         o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp_word        o_out_word
);

    localparam int IW      = $clog2(DEPTH);
    localparam int RST_CAP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    t_req_word       r_req;
    t_rsp_word       r_res;
    t_rsp_word       n_res;
    t_rsp_word       r_out_word;
    logic            r_out_valid;
    logic [IW-1:0]   r_front;
    logic [IW-1:0]   r_back;
    logic            r_empty;
    logic [IW-1:0]   r_cap_m1;
    logic [IW-1:0]   n_front;
    logic [IW-1:0]   n_back;
    logic            n_empty;
    logic [IW-1:0]   n_cap_m1;

    logic                  w_full;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [IW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [63:0]           w_rd_ext;
    logic [31:0]           w_cfg_ext;

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] x,
                                              input logic [IW-1:0] cm1);
        return (x >= cm1) ? '0 : x + IW'(1);
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] x,
                                                input logic [IW-1:0] cm1);
        return (x == '0 || x > cm1) ? cm1 : x - IW'(1);
    endfunction

    // slot read is issued at capture, data is ready in the execute cycle
    assign w_raddr = (i_in_word.req_type == REQ_POP_FRONT) ? r_front : r_back;

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_full   = !r_empty && (step_up(r_back, r_cap_m1) == r_front);
    assign w_wdata  = DATA_WIDTH'(64'($unsigned(r_req.push_value)));
    assign w_rd_ext = 64'(w_rdata);

    // clamp of the written capacity to 1..DEPTH, held as capacity minus one
    assign w_cfg_ext = 32'(i_cfg_wdata);
    always_comb begin
        priority if (w_cfg_ext == 32'd0) begin
            n_cap_m1 = '0;
        end else if (w_cfg_ext > 32'(DEPTH)) begin
            n_cap_m1 = IW'(DEPTH - 1);
        end else begin
            n_cap_m1 = IW'(w_cfg_ext - 32'd1);
        end
    end

    always_comb begin
        n_front          = r_front;
        n_back           = r_back;
        n_empty          = r_empty;
        w_we             = 1'b0;
        w_waddr          = r_back;
        n_res.pop_value  = '0;
        n_res.status     = ST_OK;
        unique case (r_req.req_type)
            REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_res.status = ST_OVERFLOW;
                end else begin
                    if (r_empty) begin
                        n_front = r_cap_m1;
                        n_back  = r_cap_m1;
                        n_empty = 1'b0;
                    end else begin
                        n_front = step_down(r_front, r_cap_m1);
                    end
                    w_we    = 1'b1;
                    w_waddr = n_front;
                end
            end
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_res.status = ST_OVERFLOW;
                end else begin
                    if (r_empty) begin
                        n_front = '0;
                        n_back  = '0;
                        n_empty = 1'b0;
                    end else begin
                        n_back = step_up(r_back, r_cap_m1);
                    end
                    w_we    = 1'b1;
                    w_waddr = n_back;
                end
            end
            REQ_POP_FRONT: begin
                if (r_empty) begin
                    n_res.status = ST_UNDERFLOW;
                end else begin
                    n_res.pop_value = w_rd_ext[31:0];
                    if (r_front == r_back) begin
                        n_front = '0;
                        n_back  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_front = step_up(r_front, r_cap_m1);
                    end
                end
            end
            REQ_POP_BACK: begin
                if (r_empty) begin
                    n_res.status = ST_UNDERFLOW;
                end else begin
                    n_res.pop_value = w_rd_ext[31:0];
                    if (r_front == r_back) begin
                        n_front = '0;
                        n_back  = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_back = step_down(r_back, r_cap_m1);
                    end
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
        // store writes only happen in the execute cycle
        w_we = w_we && i_cmd.exec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_empty     <= 1'b1;
            r_cap_m1    <= IW'(RST_CAP - 1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap_m1 <= n_cap_m1;
                r_front  <= '0;
                r_back   <= '0;
                r_empty  <= 1'b1;
            end else if (i_cmd.exec) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_empty <= n_empty;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (i_cmd.load_out) begin
            r_out_word <= r_res;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0 && r_back == '0))
        else $error("empty deque with non-zero indices");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= r_cap_m1 && r_back <= r_cap_m1))
        else $error("index beyond capacity");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_full) |-> 1'b0)
        else $error("slot written while deque full");

endmodule
